// File: design/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Implication checked in the following cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// Implication checked in the next cycle, always active.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: design/dcph_pkg.sv
package dcph_pkg;

  localparam int ROUNDS         = 16;
  localparam int ITERATIONS_DEF = 25;
  localparam int NUM_CHARS      = 8;
  localparam int CHAR_W         = 7;
  localparam int SALT_W         = 6;
  localparam int CFG_ADDR_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SALT_FIRST  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SALT_SECOND = 2'd1;

  // Payload carried down the round pipeline.
  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic [55:0] cd;
  } stage_t;

  localparam logic [6:0] TAB_FP [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};

  localparam logic [5:0] TAB_E [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};

  localparam logic [5:0] TAB_P [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};

  localparam logic [6:0] TAB_PC1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
    61,53,45,37,29,21,13,5,28,20,12,4};

  localparam logic [5:0] TAB_PC2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

  localparam int ROT_SCHED [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] SBOX [512] = '{
    14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
    4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
    15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
    0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
    10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
    13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
    7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
    10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
    2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
    4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
    12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
    9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
    4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
    1,4,11,13,12,3,7,14,10,15,6,8,9,5,0,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
    13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
    7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11};

  // Rotate one 28-bit key half left.
  function automatic logic [27:0] rot28(logic [27:0] v, int n);
    logic [27:0] res;
    res = (v << n) | (v >> (28 - n));
    return res;
  endfunction

  // Salted E expansion: salt bit j swaps entries j and j+24.
  function automatic logic [47:0] e_expand(logic [31:0] r, logic [11:0] salt);
    logic [47:0] x;
    int          idx;
    int          p;
    x = '0;
    for (int k = 0; k < 48; k++) begin
      idx = k;
      if (k < 12 && salt[k]) idx = k + 24;
      if (k >= 24 && k < 36 && salt[k-24]) idx = k - 24;
      p = 32 - int'(TAB_E[idx]);
      x[47-k] = r[p[4:0]];
    end
    return x;
  endfunction

  // DES round function with a given subkey.
  function automatic logic [31:0] f_func(logic [31:0] r, logic [47:0] subkey,
                                         logic [11:0] salt);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s_out;
    logic [31:0] res;
    logic [8:0]  addr;
    int          p;
    x = e_expand(r, salt) ^ subkey;
    s_out = '0;
    for (int s = 0; s < 8; s++) begin
      six  = x[47-6*s -: 6];
      addr = {3'(s), six[5], six[0], six[4:1]};
      s_out[31-4*s -: 4] = SBOX[addr];
    end
    res = '0;
    for (int k = 0; k < 32; k++) begin
      p = 32 - int'(TAB_P[k]);
      res[31-k] = s_out[p[4:0]];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2(logic [55:0] cd);
    logic [47:0] res;
    int          p;
    res = '0;
    for (int k = 0; k < 48; k++) begin
      p = 56 - int'(TAB_PC2[k]);
      res[47-k] = cd[p[5:0]];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1(logic [63:0] key);
    logic [55:0] res;
    int          p;
    res = '0;
    for (int k = 0; k < 56; k++) begin
      p = 64 - int'(TAB_PC1[k]);
      res[55-k] = key[p[5:0]];
    end
    return res;
  endfunction

  function automatic logic [63:0] fp(logic [63:0] lr);
    logic [63:0] res;
    int          p;
    res = '0;
    for (int k = 0; k < 64; k++) begin
      p = 64 - int'(TAB_FP[k]);
      res[63-k] = lr[p[5:0]];
    end
    return res;
  endfunction

endpackage

// File: design/dcph_keysched.sv
module dcph_keysched (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [dcph_pkg::NUM_CHARS*dcph_pkg::CHAR_W-1:0] chars,
  output logic                                        out_valid,
  output dcph_pkg::stage_t                            out_stage
);
  import dcph_pkg::*;

  logic [63:0] key;
  logic        ended;
  logic [6:0]  ch;

  // Pack characters into key bytes, zeroing from the first zero on.
  always_comb begin
    key   = '0;
    ended = 1'b0;
    ch    = '0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      ch = chars[CHAR_W*(NUM_CHARS-1-i) +: CHAR_W];
      if (ch == '0) ended = 1'b1;
      if (ended) ch = '0;
      key[63-8*i -: 8] = {ch, 1'b0};
    end
  end

  // Hold the permuted key with zero data halves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_stage.l  <= '0;
    out_stage.r  <= '0;
    out_stage.cd <= pc1(key);
  end

endmodule

// File: design/dcph_round.sv
module dcph_round #(
  parameter int ROT = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [11:0]      salt,
  input  logic             in_valid,
  input  dcph_pkg::stage_t in_stage,
  output logic             out_valid,
  output dcph_pkg::stage_t out_stage
);
  import dcph_pkg::*;

  logic [55:0] cd_next;
  logic [31:0] r_next;

  // Advance the key schedule, then run one Feistel round.
  always_comb begin
    cd_next = {rot28(in_stage.cd[55:28], ROT), rot28(in_stage.cd[27:0], ROT)};
    r_next  = in_stage.l ^ f_func(in_stage.r, pc2(cd_next), salt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_stage.l  <= in_stage.r;
    out_stage.r  <= r_next;
    out_stage.cd <= cd_next;
  end

endmodule

// File: design/des_crypt_password_hash_unit.sv
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+--------------------------
// input    | key_char0..key_char7                   | start && !busy
// result   | hash_left, hash_right                  | done, one cycle
// config   | cfg_addr, cfg_wdata                    | cfg_we
//
// An item passes through one key stage, one register stage per DES round
// and one output stage.
// A new item is taken every cycle; busy is high only during reset.
// Reset (rst, synchronous) clears the valid bits and the salt registers.
// The receiver cannot stall; each result shows for one cycle on done.
module des_crypt_password_hash_unit #(
  parameter int ITERATIONS = dcph_pkg::ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char0,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char1,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char2,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char3,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char4,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char5,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char6,
  input  logic [dcph_pkg::CHAR_W-1:0]     key_char7,
  input  logic                            cfg_we,
  input  logic [dcph_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dcph_pkg::SALT_W-1:0]     cfg_wdata,
  output logic                            done,
  output logic [31:0]                     hash_left,
  output logic [31:0]                     hash_right
);
  import dcph_pkg::*;

  localparam int NSTAGE = ITERATIONS * ROUNDS;

  logic [SALT_W-1:0] salt_first;
  logic [SALT_W-1:0] salt_second;
  logic              accept;
  logic              vld [NSTAGE+1];
  stage_t            st  [NSTAGE+1];
  logic              rvld [NSTAGE];
  stage_t            rst_out [NSTAGE];
  logic [63:0]       res;

  assign busy   = rst;
  assign accept = start && !busy;

  // Salt registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      salt_first  <= '0;
      salt_second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SALT_FIRST:  salt_first  <= cfg_wdata;
        REG_SALT_SECOND: salt_second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dcph_keysched u_key (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .chars    ({key_char0, key_char1, key_char2, key_char3,
                key_char4, key_char5, key_char6, key_char7}),
    .out_valid(vld[0]),
    .out_stage(st[0])
  );

  // One register stage per round; swap halves at each iteration end.
  for (genvar n = 0; n < NSTAGE; n++) begin : g_round
    dcph_round #(.ROT(ROT_SCHED[n % ROUNDS])) u_round (
      .clk      (clk),
      .rst      (rst),
      .salt     ({salt_second, salt_first}),
      .in_valid (vld[n]),
      .in_stage (st[n]),
      .out_valid(rvld[n]),
      .out_stage(rst_out[n])
    );
    assign vld[n+1] = rvld[n];
    if ((n % ROUNDS) == ROUNDS - 1) begin : g_swap
      assign st[n+1] = '{l: rst_out[n].r, r: rst_out[n].l, cd: rst_out[n].cd};
    end else begin : g_pass
      assign st[n+1] = rst_out[n];
    end
  end

  assign res = fp({st[NSTAGE].l, st[NSTAGE].r});

  // Final permutation into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NSTAGE];
    end
    hash_left  <= res[63:32];
    hash_right <= res[31:0];
  end

endmodule

// File: design/dcph_checker.sv
`include "assert_macros.svh"

module dcph_checker #(
  parameter int ITERATIONS = dcph_pkg::ITERATIONS_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import dcph_pkg::*;

  localparam int LAT = ITERATIONS * ROUNDS + 2;

  logic accepted;
  assign accepted = start && !busy;

  // Every accepted item comes out after the fixed latency.
  `ASSERT_IMPLY(a_lat_fwd, clk, rst, accepted, ##LAT done)
  // A result only appears for an item that was accepted.
  `ASSERT_IMPLY(a_lat_back, clk, rst, done, $past(accepted, LAT))
  // Reset drops any item in flight.
  `ASSERT_NEXT_ALWAYS(a_rst_flush, clk, rst, !done)
  // Outside reset the block always takes items.
  `ASSERT_NEXT(a_ready, clk, rst, !rst, !busy || rst)

endmodule

bind des_crypt_password_hash_unit dcph_checker #(.ITERATIONS(ITERATIONS)) u_dcph_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dcph_pkg::*;

  localparam int LATENCY     = ITERATIONS_DEF * ROUNDS + 2;
  localparam int STALL_LIMIT = 20 * LATENCY;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

  typedef logic [CHAR_W-1:0] pw_chars_t [NUM_CHARS];

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [CHAR_W-1:0] key_char0, key_char1, key_char2, key_char3;
  logic [CHAR_W-1:0] key_char4, key_char5, key_char6, key_char7;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [SALT_W-1:0] cfg_wdata;
  logic done;
  logic [31:0] hash_left;
  logic [31:0] hash_right;

  // Salt as the predictor sees it, and hashes still owed by the block.
  logic [SALT_W-1:0] salt_lo_q;
  logic [SALT_W-1:0] salt_hi_q;
  logic [63:0]       pending_hashes [$];
  int                errors;
  int                items_sent;
  int                hashes_seen;
  int                idle_pct;

  des_crypt_password_hash_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .key_char0(key_char0), .key_char1(key_char1), .key_char2(key_char2),
    .key_char3(key_char3), .key_char4(key_char4), .key_char5(key_char5),
    .key_char6(key_char6), .key_char7(key_char7),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .done(done), .hash_left(hash_left), .hash_right(hash_right)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Salted 25-pass DES of the zero block under the password key.
  function automatic logic [63:0] crypt_hash(pw_chars_t pw, logic [11:0] salt);
    logic [63:0] key;
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [47:0] subkey [ROUNDS];
    int          etab [48];
    int          tmp;
    logic [31:0] l, r, t, s_out, f_out;
    logic [47:0] x;
    logic [5:0]  six;
    logic [63:0] lr, res;
    bit          ended;
    ended = 1'b0;
    key = '0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (pw[i] == '0) ended = 1'b1;
      if (!ended) key[63-8*i -: 8] = {pw[i], 1'b0};
    end
    for (int k = 0; k < 56; k++) cd[55-k] = key[64 - int'(TAB_PC1[k])];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < ROUNDS; i++) begin
      for (int n = 0; n < ROT_SCHED[i]; n++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int k = 0; k < 48; k++) subkey[i][47-k] = cd[56 - int'(TAB_PC2[k])];
    end
    for (int k = 0; k < 48; k++) etab[k] = int'(TAB_E[k]);
    for (int j = 0; j < 12; j++) begin
      if (salt[j]) begin
        tmp = etab[j];
        etab[j] = etab[j+24];
        etab[j+24] = tmp;
      end
    end
    l = '0;
    r = '0;
    for (int it = 0; it < ITERATIONS_DEF; it++) begin
      for (int i = 0; i < ROUNDS; i++) begin
        for (int k = 0; k < 48; k++) x[47-k] = r[32 - etab[k]];
        x = x ^ subkey[i];
        for (int s = 0; s < 8; s++) begin
          six = x[47-6*s -: 6];
          s_out[31-4*s -: 4] = SBOX[s*64 + {six[5], six[0]}*16 + six[4:1]];
        end
        for (int k = 0; k < 32; k++) f_out[31-k] = s_out[32 - int'(TAB_P[k])];
        t = r;
        r = l ^ f_out;
        l = t;
      end
      t = l;
      l = r;
      r = t;
    end
    lr = {l, r};
    for (int k = 0; k < 64; k++) res[63-k] = lr[64 - int'(TAB_FP[k])];
    return res;
  endfunction

  // Compare each strobed hash with the oldest one owed.
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && done) begin
      hashes_seen++;
      if (pending_hashes.size() == 0) begin
        $error("unexpected hash %h_%h", hash_left, hash_right);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_left !== want[63:32]) begin
          $error("hash_left expected %h actual %h", want[63:32], hash_left);
          errors++;
        end
        if (hash_right !== want[31:0]) begin
          $error("hash_right expected %h actual %h", want[31:0], hash_right);
          errors++;
        end
      end
    end
  end

  // Abort when neither side moves for too long.
  always @(posedge clk) begin
    int quiet;
    if (rst || (start && !busy) || done) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one item; unless an idle gap is drawn, start stays high on return so back-to-back items stay seamless.
  task automatic send_item(pw_chars_t pw);
    {key_char0, key_char1, key_char2, key_char3} = {pw[0], pw[1], pw[2], pw[3]};
    {key_char4, key_char5, key_char6, key_char7} = {pw[4], pw[5], pw[6], pw[7]};
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_hashes.push_back(crypt_hash(pw, {salt_hi_q, salt_lo_q}));
    items_sent++;
    @(negedge clk);
    while ($urandom_range(99, 0) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop start, then wait out every owed hash.
  task automatic drain();
    start = 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [SALT_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SALT_FIRST) salt_lo_q = val;
    else if (idx == REG_SALT_SECOND) salt_hi_q = val;
  endtask

  function automatic pw_chars_t fill_chars(logic [CHAR_W-1:0] v);
    pw_chars_t pw;
    foreach (pw[i]) pw[i] = v;
    return pw;
  endfunction

  // Random password: mostly printable, sometimes short, sometimes raw bits.
  function automatic pw_chars_t random_password();
    pw_chars_t pw;
    int        len;
    len = $urandom_range(8, 0);
    foreach (pw[i]) begin
      if ($urandom_range(3, 0) == 0) pw[i] = CHAR_W'($urandom_range(127, 0));
      else if (i < len) pw[i] = CHAR_W'($urandom_range(126, 32));
      else pw[i] = (i == len) ? '0 : CHAR_W'($urandom_range(127, 0));
    end
    return pw;
  endfunction

  // Extreme characters and early key endings.
  task automatic test_key_corners();
    pw_chars_t pw;
    send_item(fill_chars('0));
    send_item(fill_chars(7'h7F));
    send_item(fill_chars(7'h55));
    send_item(fill_chars(7'h2A));
    for (int z = 0; z < NUM_CHARS; z++) begin
      pw = fill_chars(7'h7F);
      pw[z] = '0;
      send_item(pw);
    end
    pw = '{7'h70, 7'h61, 7'h73, 7'h73, 7'h77, 7'h6F, 7'h72, 7'h64};
    send_item(pw);
    pw = '{7'h41, 7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F};
    send_item(pw);
  endtask

  // Extreme salts, then check writes to spare indexes leave the salt alone.
  task automatic test_salt_corners();
    pw_chars_t pw;
    pw = '{7'h74, 7'h65, 7'h73, 7'h74, 7'h00, 7'h00, 7'h00, 7'h00};
    for (int s = 0; s < 4; s++) begin
      drain();
      write_reg(REG_SALT_FIRST, s[0] ? 6'h3F : 6'h00);
      write_reg(REG_SALT_SECOND, s[1] ? 6'h3F : 6'h00);
      send_item(pw);
      send_item(fill_chars(7'h7F));
    end
    drain();
    write_reg(REG_SALT_FIRST, 6'h2E);
    write_reg(REG_SALT_SECOND, 6'h15);
    write_reg(REG_SPARE_LO, 6'h3F);
    write_reg(REG_SPARE_HI, 6'h00);
    send_item(pw);
  endtask

  // Random passwords under one random salt per phase.
  task automatic test_random_phase(int pct, int count);
    idle_pct = pct;
    drain();
    write_reg(REG_SALT_FIRST, SALT_W'($urandom_range(63, 0)));
    write_reg(REG_SALT_SECOND, SALT_W'($urandom_range(63, 0)));
    for (int n = 0; n < count; n++) begin
      send_item(random_password());
      // Occasionally hold off until the pipeline is empty.
      if ($urandom_range(199, 0) == 0) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_SALT_FIRST;
    cfg_wdata = '0;
    {key_char0, key_char1, key_char2, key_char3} = '0;
    {key_char4, key_char5, key_char6, key_char7} = '0;
    salt_lo_q = '0;
    salt_hi_q = '0;
    errors = 0;
    items_sent = 0;
    hashes_seen = 0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_key_corners();
    test_salt_corners();
    test_random_phase(26, 250);
    test_random_phase(26, 250);
    test_random_phase(76, 250);
    test_random_phase(76, 250);
    test_random_phase(0, 250);
    test_random_phase(0, 250);

    drain();
    repeat (LATENCY + 20) @(negedge clk);
    $display("%0d passwords hashed, %0d hashes checked", items_sent, hashes_seen);
    $display("covered key ends, extreme and random salts, spare register writes");
    if (errors == 0 && pending_hashes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
